// ===== rtl/ggb_pkg.sv =====
package ggb_pkg;

  localparam int FRAME_W    = 13;
  localparam int COORD_W    = 12;
  localparam int IDX_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // input item kinds
  localparam logic [1:0] KIND_GRAY     = 2'd0;
  localparam logic [1:0] KIND_SUBPIXEL = 2'd1;
  localparam logic [1:0] KIND_LOAD_FWD = 2'd2;
  localparam logic [1:0] KIND_LOAD_INV = 2'd3;

  // operations carried through the queue and the back pipeline
  typedef logic [1:0] op_t;
  localparam op_t OP_BLEND    = 2'd0;
  localparam op_t OP_LOAD_FWD = 2'd1;
  localparam op_t OP_LOAD_INV = 2'd2;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [IDX_W-1:0]   table_index;
    logic [IDX_W-1:0]   table_value;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [23:0] coverage;
    logic [23:0] fore_color;
    logic [23:0] back_color;
  } q_entry_t;

endpackage

// ===== rtl/ggb_if.sv =====
interface ggb_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [23:0]        coverage;
  logic [23:0]        fore_color;
  logic [23:0]        back_color;
  logic [10:0]        table_index;
  logic [10:0]        table_value;

  modport source (
    output valid, kind, pixel_x, pixel_y, coverage, fore_color, back_color,
           table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_x, pixel_y, coverage, fore_color, back_color,
           table_index, table_value,
    output ready
  );
endinterface

interface ggb_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic [23:0] out_color;

  modport source (output valid, out_x, out_y, out_color, input ready);
  modport sink   (input valid, out_x, out_y, out_color, output ready);
endinterface

// ===== rtl/gamma_correct_glyph_blend_core.sv =====
// Gamma-correct glyph blend core.
// item channel (valid/ready): one item per transfer. Kinds gray and subpixel
// blend fore_color over back_color at (pixel_x, pixel_y) with the coverage
// bytes; kinds load forward / load inverse write one gamma table entry.
// result channel (valid/ready): one pixel write per blend inside the frame.
// Clipped pixels and loads are taken and give no result.
// Config: cfg_wr_en/cfg_index/cfg_data write frame_width (0) and
// frame_height (1); write only while the core is idle.
// Throughput: one item per cycle while the queue is not full. An accepted item
// passes a queue slot, then the forward table read, multiply, abs, divide
// fixup and inverse table read registers before its result is shown.
// A 4-entry queue sits between the front classifier and the back pipeline;
// item.ready drops only when that queue is full.
// When result.ready is low with a result shown, the back pipeline freezes
// and the queue fills, then item.ready goes low.
// Reset clears the pipeline and queue and sets the frame to 640x480.
// Gamma tables are not cleared; load every entry before it is used.
module gamma_correct_glyph_blend_core #(
  parameter int LINEAR_BITS = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  ggb_item_if.sink                        item,
  ggb_result_if.source                    result,
  input  logic                            cfg_wr_en,
  input  logic [ggb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ggb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ggb_pkg::*;

  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic               push;
  q_entry_t           push_entry;
  logic               full;
  logic               head_vld;
  q_entry_t           head;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ggb_front #(.LINEAR_BITS(LINEAR_BITS)) u_front (
    .item         (item),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .full         (full),
    .push         (push),
    .push_entry   (push_entry)
  );

  ggb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_vld   (head_vld),
    .head       (head)
  );

  ggb_back #(.LINEAR_BITS(LINEAR_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop),
    .result   (result)
  );

  // a full queue must have something at its head
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> head_vld)
    else $error("queue full with no head entry");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_vld)
    else $error("pop from empty queue");

  // back pipeline must freeze while a result waits
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !pop)
    else $error("queue popped while result stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule

// ===== rtl/ggb_front.sv =====
module ggb_front #(
  parameter int LINEAR_BITS = 11
) (
  ggb_item_if.sink                   item,
  input  logic [ggb_pkg::FRAME_W-1:0] frame_width,
  input  logic [ggb_pkg::FRAME_W-1:0] frame_height,
  input  logic                       full,
  output logic                       push,
  output ggb_pkg::q_entry_t          push_entry
);
  import ggb_pkg::*;

  logic in_x;
  logic in_y;
  logic inv_idx_ok;
  logic keep;

  // x below 4096 and below the frame width covers the 4096 cap as well
  assign in_x = !item.pixel_x[15] && (item.pixel_x[14:12] == 3'b000) &&
                ({1'b0, item.pixel_x[11:0]} < frame_width);
  assign in_y = !item.pixel_y[15] && (item.pixel_y[14:12] == 3'b000) &&
                ({1'b0, item.pixel_y[11:0]} < frame_height);

  assign inv_idx_ok = (LINEAR_BITS >= IDX_W) ||
                      ((32'(item.table_index) >> LINEAR_BITS) == 32'd0);

  always_comb begin
    push_entry.tag.x           = item.pixel_x[11:0];
    push_entry.tag.y           = item.pixel_y[11:0];
    push_entry.tag.table_index = item.table_index;
    push_entry.tag.table_value = item.table_value;
    push_entry.fore_color      = item.fore_color;
    push_entry.back_color      = item.back_color;
    push_entry.coverage        = item.coverage;
    push_entry.tag.op          = OP_BLEND;
    keep                       = 1'b0;
    case (item.kind)
      KIND_GRAY: begin
        push_entry.coverage = {3{item.coverage[7:0]}};
        keep                = in_x && in_y;
      end
      KIND_SUBPIXEL: begin
        keep = in_x && in_y;
      end
      KIND_LOAD_FWD: begin
        push_entry.tag.op = OP_LOAD_FWD;
        keep              = (item.table_index[10:8] == 3'b000);
      end
      KIND_LOAD_INV: begin
        push_entry.tag.op = OP_LOAD_INV;
        keep              = inv_idx_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // clipped pixels and out-of-range loads are taken and dropped here
  assign item.ready = !full;
  assign push       = item.valid && !full && keep;

endmodule

// ===== rtl/ggb_queue.sv =====
module ggb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ggb_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              head_vld,
  output ggb_pkg::q_entry_t head
);
  import ggb_pkg::*;

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_vld = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

// ===== rtl/ggb_back.sv =====
module ggb_back #(
  parameter int LINEAR_BITS = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_vld,
  input  ggb_pkg::q_entry_t head,
  output logic              pop,
  ggb_result_if.source      result
);
  import ggb_pkg::*;

  localparam int L        = LINEAR_BITS;
  localparam int NW       = L + 8;
  localparam int PW       = 2 * L + 2;
  localparam int INV_SIZE = 1 << L;
  localparam logic [L-1:0]         LIN_MAX = {L{1'b1}};
  localparam logic signed [PW-1:0] BIAS    = PW'((1 << (L - 1)) - 1);

  logic adv;
  logic fwd_we;
  logic inv_we;
  logic st1_vld, st2_vld, st3_vld, st4_vld, st5_vld;
  tag_t st1_tag, st2_tag, st3_tag, st4_tag, st5_tag;
  logic [7:0] ch_color [3];

  // whole pipeline moves together; only an untaken result holds it
  assign adv    = !(st5_vld && (st5_tag.op == OP_BLEND)) || result.ready;
  assign pop    = adv && head_vld;
  assign fwd_we = pop && (head.tag.op == OP_LOAD_FWD);
  assign inv_we = adv && st4_vld && (st4_tag.op == OP_LOAD_INV);

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld <= 1'b0;
      st2_vld <= 1'b0;
      st3_vld <= 1'b0;
      st4_vld <= 1'b0;
      st5_vld <= 1'b0;
    end else if (adv) begin
      st1_vld <= head_vld;
      st2_vld <= st1_vld;
      st3_vld <= st2_vld;
      st4_vld <= st3_vld;
      st5_vld <= st4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_tag <= head.tag;
      st2_tag <= st1_tag;
      st3_tag <= st2_tag;
      st4_tag <= st3_tag;
      st5_tag <= st4_tag;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [L-1:0]         fwd_mem [0:255];
    logic [7:0]           inv_mem [0:INV_SIZE-1];
    logic [7:0]           cov;
    logic [NW-1:0]        cov_lin;
    logic [NW+8:0]        cov_recip;
    logic [L-1:0]         cov_q0;
    logic [NW-1:0]        cov_rem;
    logic [L-1:0]         cov_q;
    logic [L-1:0]         st1_fg, st1_bg, st1_inv;
    logic signed [L:0]    diff, inv_s;
    logic signed [PW-1:0] st2_prod;
    logic [L-1:0]         st2_fg;
    logic signed [PW-1:0] num;
    logic [PW-1:0]        mag;
    logic [2*L-1:0]       st3_mag;
    logic                 st3_neg;
    logic [L-1:0]         st3_fg;
    logic [L-1:0]         q0;
    logic [L:0]           rem;
    logic [L:0]           q;
    logic signed [L+1:0]  st4_q;
    logic [L-1:0]         st4_fg;
    logic signed [L+1:0]  lin_sum;
    logic [L-1:0]         lin;
    logic [7:0]           st5_color;

    // inverse weight M - floor(a * M / 255); n*257 >> 16 is at most one low
    always_comb begin
      cov       = head.coverage[8*c +: 8];
      cov_lin   = (NW'(cov) << L) - NW'(cov);
      cov_recip = ((NW + 9)'(cov_lin) << 8) + (NW + 9)'(cov_lin);
      cov_q0    = cov_recip[L+15:16];
      cov_rem   = cov_lin - ((NW'(cov_q0) << 8) - NW'(cov_q0));
      cov_q     = (cov_rem >= NW'(255)) ? cov_q0 + L'(1) : cov_q0;
    end

    always_ff @(posedge clk) begin
      if (fwd_we) fwd_mem[head.tag.table_index[7:0]] <= L'(head.tag.table_value);
      if (pop) begin
        st1_fg <= fwd_mem[head.fore_color[8*c +: 8]];
        st1_bg <= fwd_mem[head.back_color[8*c +: 8]];
      end
      if (adv) st1_inv <= LIN_MAX - cov_q;
    end

    assign diff  = $signed({1'b0, st1_bg}) - $signed({1'b0, st1_fg});
    assign inv_s = $signed({1'b0, st1_inv});

    always_ff @(posedge clk) begin
      if (adv) begin
        st2_prod <= PW'(diff) * PW'(inv_s);
        st2_fg   <= st1_fg;
      end
    end

    // signed truncating divide by M done on the magnitude
    always_comb begin
      num = st2_prod + BIAS;
      mag = num[PW-1] ? -num : num;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st3_mag <= mag[2*L-1:0];
        st3_neg <= num[PW-1];
        st3_fg  <= st2_fg;
      end
    end

    // mag / (2^L - 1): estimate mag >> L, fix up by one
    always_comb begin
      q0  = st3_mag[2*L-1:L];
      rem = (L + 1)'(st3_mag[L-1:0]) + (L + 1)'(q0);
      q   = (rem >= (L + 1)'(LIN_MAX)) ? (L + 1)'(q0) + (L + 1)'(1) : (L + 1)'(q0);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st4_q  <= st3_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        st4_fg <= st3_fg;
      end
    end

    always_comb begin
      lin_sum = $signed({2'b00, st4_fg}) + st4_q;
      if (lin_sum[L+1]) begin
        lin = '0;
      end else if (lin_sum[L]) begin
        lin = LIN_MAX;
      end else begin
        lin = lin_sum[L-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (inv_we) inv_mem[L'(st4_tag.table_index)] <= st4_tag.table_value[7:0];
      if (adv) st5_color <= inv_mem[lin];
    end

    assign ch_color[c] = st5_color;
  end

  assign result.valid     = st5_vld && (st5_tag.op == OP_BLEND);
  assign result.out_x     = st5_tag.x;
  assign result.out_y     = st5_tag.y;
  assign result.out_color = {ch_color[2], ch_color[1], ch_color[0]};

endmodule

// ===== test/ggb_blend_checker.sv =====
`timescale 1ns / 1ps

module ggb_blend_checker #(
  parameter int LINEAR_BITS = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  ggb_item_if                            item,
  ggb_result_if                          result,
  input  logic                           cfg_wr_en,
  input  logic [ggb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ggb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             mismatches
);
  import ggb_pkg::*;

  localparam int LIN_MAX   = (1 << LINEAR_BITS) - 1;
  localparam int LUT_DEPTH = 1 << LINEAR_BITS;
  localparam int FRAME_CAP = 4096;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [23:0]        color;
  } pixel_write_t;

  pixel_write_t             writes_due[$];
  logic [LINEAR_BITS-1:0]   fwd_lut [256];
  logic [7:0]               inv_lut [LUT_DEPTH];
  logic [FRAME_W-1:0]       frame_w;
  logic [FRAME_W-1:0]       frame_h;
  int                       err_cnt = 0;

  assign mismatches = err_cnt;

  task automatic flag_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // one color channel: to linear, mix toward bg by inverse coverage, back to 8 bits
  function automatic logic [7:0] blend_channel(input logic [7:0] fgc, input logic [7:0] bgc,
                                               input logic [7:0] cov);
    int fg, bg, inv, num, lin;
    fg  = int'(fwd_lut[fgc]);
    bg  = int'(fwd_lut[bgc]);
    inv = LIN_MAX - (int'(cov) * LIN_MAX) / 255;
    num = (bg - fg) * inv + (1 << (LINEAR_BITS - 1)) - 1;
    lin = fg + num / LIN_MAX;  // signed division truncates toward zero
    if (lin < 0) lin = 0;
    if (lin > LIN_MAX) lin = LIN_MAX;
    return inv_lut[lin[LINEAR_BITS-1:0]];
  endfunction

  always @(posedge clk) begin : monitor
    pixel_write_t got, want;
    int           xi, yi, wi, hi;
    logic [7:0]   cg, cb;
    if (rst) begin
      frame_w = FRAME_WIDTH_RESET;
      frame_h = FRAME_HEIGHT_RESET;
      writes_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_w = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) frame_h = cfg_data;
      end

      // compare before pushing: a result never belongs to an item of the same edge
      if (result.valid && result.ready) begin
        got.x     = result.out_x;
        got.y     = result.out_y;
        got.color = result.out_color;
        if (writes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel write (%0d,%0d) color %06h",
                                  got.x, got.y, got.color));
        end else begin
          want = writes_due.pop_front();
          if (got.x != want.x)
            flag_mismatch($sformatf("out_x %0d, want %0d", got.x, want.x));
          if (got.y != want.y)
            flag_mismatch($sformatf("out_y %0d, want %0d", got.y, want.y));
          if (got.color != want.color)
            flag_mismatch($sformatf("out_color %06h, want %06h at (%0d,%0d)",
                                    got.color, want.color, want.x, want.y));
        end
      end

      if (item.valid && item.ready) begin
        case (item.kind)
          KIND_LOAD_FWD: begin
            if (item.table_index < 256)
              fwd_lut[item.table_index[7:0]] = item.table_value[LINEAR_BITS-1:0];
          end
          KIND_LOAD_INV: begin
            if (item.table_index < LUT_DEPTH)
              inv_lut[item.table_index] = item.table_value[7:0];
          end
          default: begin
            xi = int'(item.pixel_x);
            yi = int'(item.pixel_y);
            wi = (int'(frame_w) > FRAME_CAP) ? FRAME_CAP : int'(frame_w);
            hi = (int'(frame_h) > FRAME_CAP) ? FRAME_CAP : int'(frame_h);
            if (xi >= 0 && xi < wi && yi >= 0 && yi < hi) begin
              // grayscale: red coverage byte drives all three channels
              cg = (item.kind == KIND_GRAY) ? item.coverage[7:0] : item.coverage[15:8];
              cb = (item.kind == KIND_GRAY) ? item.coverage[7:0] : item.coverage[23:16];
              want.x     = xi[11:0];
              want.y     = yi[11:0];
              want.color = {blend_channel(item.fore_color[23:16], item.back_color[23:16], cb),
                            blend_channel(item.fore_color[15:8], item.back_color[15:8], cg),
                            blend_channel(item.fore_color[7:0], item.back_color[7:0],
                                          item.coverage[7:0])};
              writes_due.insert(writes_due.size(), want);
            end
          end
        endcase
      end
    end
    pending <= writes_due.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ggb_pkg::*;

  localparam int IDLE_PCT       = 34;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  // forward entries stay in 0..FWD_SPAN, so a blend only reads inverse
  // entries 0..FWD_SPAN; those are all loaded up front
  localparam int FWD_SPAN       = 511;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [23:0]        cov;
    logic [23:0]        fg;
    logic [23:0]        bg;
    logic [10:0]        tidx;
    logic [10:0]        tval;
  } glyph_item_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    mismatches;
  bit                    steady_flow = 1'b0;
  int                    cur_w = 640;
  int                    cur_h = 480;
  int                    quiet_cycles = 0;

  ggb_item_if   item_ch();
  ggb_result_if result_ch();

  gamma_correct_glyph_blend_core uut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ggb_blend_checker pixel_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gamma_correct_glyph_blend_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic glyph_item_t mk_blend(input logic [1:0] kind, input int x, input int y,
                                           input logic [23:0] cov, input logic [23:0] fg,
                                           input logic [23:0] bg);
    glyph_item_t it;
    it.kind = kind;
    it.px   = 16'(x);
    it.py   = 16'(y);
    it.cov  = cov;
    it.fg   = fg;
    it.bg   = bg;
    it.tidx = 11'($urandom);
    it.tval = 11'($urandom);
    return it;
  endfunction

  function automatic glyph_item_t mk_load(input logic [1:0] kind, input int idx, input int val);
    glyph_item_t it;
    it.kind = kind;
    it.px   = 16'($urandom);
    it.py   = 16'($urandom);
    it.cov  = 24'($urandom);
    it.fg   = 24'($urandom);
    it.bg   = 24'($urandom);
    it.tidx = 11'(idx);
    it.tval = 11'(val);
    return it;
  endfunction

  // mostly inside the frame, the rest on the clip edges or anywhere
  function automatic int pick_coord(input int lim);
    if (lim > 0 && $urandom_range(99) < 85) return $urandom_range(lim - 1);
    case ($urandom_range(5))
      0:       return -1;
      1:       return lim;
      2:       return -32768;
      3:       return 32767;
      4:       return lim - 1;
      default: return $signed($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic logic [23:0] pick_rgb24();
    case ($urandom_range(9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic glyph_item_t random_item();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return mk_blend($urandom_range(1) ? KIND_SUBPIXEL : KIND_GRAY,
                      pick_coord(cur_w), pick_coord(cur_h),
                      pick_rgb24(), pick_rgb24(), pick_rgb24());
    else if (r < 85)
      // now and then an index past the forward table, which must be ignored
      return mk_load(KIND_LOAD_FWD,
                     ($urandom_range(9) == 0) ? $urandom_range(2047, 256) : $urandom_range(255),
                     $urandom_range(FWD_SPAN));
    else
      return mk_load(KIND_LOAD_INV, $urandom_range(2047), $urandom_range(2047));
  endfunction

  task automatic send_item(input glyph_item_t it);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= it.kind;
    item_ch.pixel_x     <= it.px;
    item_ch.pixel_y     <= it.py;
    item_ch.coverage    <= it.cov;
    item_ch.fore_color  <= it.fg;
    item_ch.back_color  <= it.bg;
    item_ch.table_index <= it.tidx;
    item_ch.table_value <= it.tval;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // stop sending and let every pending pixel write come out
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int n, input bit pause_mid,
                           input bit steady);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= 13'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= 13'(h);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    steady_flow <= steady;
    cur_w = (w > 4096) ? 4096 : w;
    cur_h = (h > 4096) ? 4096 : h;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) settle();
      send_item(random_item());
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = REG_FRAME_WIDTH;
    cfg_data            = '0;
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_GRAY;
    item_ch.pixel_x     = '0;
    item_ch.pixel_y     = '0;
    item_ch.coverage    = '0;
    item_ch.fore_color  = '0;
    item_ch.back_color  = '0;
    item_ch.table_index = '0;
    item_ch.table_value = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fill both gamma tables before any blend reads them
    for (int i = 0; i < 256; i++)
      send_item(mk_load(KIND_LOAD_FWD, i, (i * i * FWD_SPAN + 32512) / 65025));
    for (int v = 0; v <= FWD_SPAN; v++)
      send_item(mk_load(KIND_LOAD_INV, v, (v * 255 + FWD_SPAN / 2) / FWD_SPAN));

    // directed, at the reset frame of 640x480
    send_item(mk_blend(KIND_GRAY, 0, 0, 24'h000000, 24'h000000, 24'hFFFFFF));
    send_item(mk_blend(KIND_GRAY, 639, 479, 24'h0000FF, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_GRAY, 320, 240, 24'h000080, 24'h123456, 24'hABCDEF));
    send_item(mk_blend(KIND_SUBPIXEL, 1, 2, 24'h00FF80, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_SUBPIXEL, 638, 0, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF));
    send_item(mk_blend(KIND_SUBPIXEL, 0, 478, 24'h000000, 24'h808080, 24'h808080));
    // clipped on each side
    send_item(mk_blend(KIND_GRAY, -1, 0, 24'h0000FF, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_GRAY, 640, 0, 24'h0000FF, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_GRAY, 0, 480, 24'h0000FF, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_GRAY, 0, -1, 24'h0000FF, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_SUBPIXEL, -32768, -32768, 24'hFFFFFF, 24'hFFFFFF, 24'h0));
    send_item(mk_blend(KIND_SUBPIXEL, 32767, 32767, 24'hFFFFFF, 24'hFFFFFF, 24'h0));
    // table loads, including out-of-range indexes and wide values
    send_item(mk_load(KIND_LOAD_FWD, 255, FWD_SPAN));
    send_item(mk_load(KIND_LOAD_FWD, 0, 0));
    send_item(mk_load(KIND_LOAD_FWD, 256, 1));
    send_item(mk_load(KIND_LOAD_FWD, 2047, 2047));
    send_item(mk_load(KIND_LOAD_INV, 2047, 2047));
    send_item(mk_load(KIND_LOAD_INV, 0, 11'h700));
    send_item(mk_load(KIND_LOAD_INV, 1024, 11'h0FF));
    send_item(mk_blend(KIND_GRAY, 5, 5, 24'h0000FF, 24'hFFFFFF, 24'h000000));
    send_item(mk_blend(KIND_SUBPIXEL, 6, 6, 24'h00FF00, 24'h00FFFF, 24'hFF0000));
    send_item(mk_blend(KIND_GRAY, 7, 7, 24'h000001, 24'hFF00FF, 24'h00FF00));

    run_phase(4096, 4096, 50, 1'b0, 1'b0);
    run_phase(8191, 8191, 50, 1'b1, 1'b0);
    run_phase(0, 0, 20, 1'b0, 1'b0);
    run_phase(1, 1, 20, 1'b0, 1'b0);
    run_phase(4095, 7, 40, 1'b0, 1'b0);
    run_phase(33, 4096, 40, 1'b0, 1'b0);
    run_phase($urandom_range(8191, 1), $urandom_range(8191, 1), 30, 1'b0, 1'b0);
    run_phase(640, 480, 70, 1'b0, 1'b1);
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("gamma_correct_glyph_blend_core test passed");
    end else begin
      $display("gamma_correct_glyph_blend_core test failed");
    end
    $finish;
  end

endmodule
